// ----- rtl/tcpop_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tcpop_pkg;

  // local window scale applied once the peer offers scaling
  localparam logic [2:0] LOCAL_SHIFT_ON = 3'd7;

  // option kinds
  localparam logic [7:0] KIND_EOL    = 8'd0;
  localparam logic [7:0] KIND_NOP    = 8'd1;
  localparam logic [7:0] KIND_MSS    = 8'd2;
  localparam logic [7:0] KIND_WSCALE = 8'd3;
  localparam logic [7:0] KIND_SACKOK = 8'd4;

  // end of walk causes
  localparam logic [1:0] CAUSE_RAN_OUT   = 2'd0;
  localparam logic [1:0] CAUSE_EOL       = 2'd1;
  localparam logic [1:0] CAUSE_TRUNCATED = 2'd2;
  localparam logic [1:0] CAUSE_ZERO_LEN  = 2'd3;

  typedef struct packed {
    logic        mss_seen;
    logic [15:0] peer_mss;
    logic        scale_seen;
    logic [7:0]  peer_shift;
    logic [2:0]  own_shift;
    logic        sack_seen;
    logic [1:0]  end_cause;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/tcpop_walk.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tcpop_walk (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                adv,
  input  wire  [7:0]         opt_byte,
  input  wire                last,
  output tcpop_pkg::res_t    res
);
  import tcpop_pkg::*;

  localparam logic [1:0] PH_KIND = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;
  localparam logic [1:0] PH_STOP = 2'd3;

  logic [1:0]  phase_r, phase_nxt;
  logic [7:0]  kind_r, kind_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [15:0] field_r, field_nxt;
  logic [1:0]  stop_r, stop_nxt;
  logic        mss_flag_r, mss_flag_nxt;
  logic [15:0] mss_val_r, mss_val_nxt;
  logic        scale_flag_r, scale_flag_nxt;
  logic [7:0]  scale_val_r, scale_val_nxt;
  logic [2:0]  lshift_r, lshift_nxt;
  logic        sack_flag_r, sack_flag_nxt;
  logic [7:0]  left_dec;
  logic [15:0] field_sh;
  logic [1:0]  cause;

  assign field_sh = {field_r[7:0], opt_byte};
  assign left_dec = (left_r != 8'd0) ? (left_r - 8'd1) : left_r;

  always_comb begin
    phase_nxt      = phase_r;
    kind_nxt       = kind_r;
    left_nxt       = left_r;
    field_nxt      = field_r;
    stop_nxt       = stop_r;
    mss_flag_nxt   = mss_flag_r;
    mss_val_nxt    = mss_val_r;
    scale_flag_nxt = scale_flag_r;
    scale_val_nxt  = scale_val_r;
    lshift_nxt     = lshift_r;
    sack_flag_nxt  = sack_flag_r;
    unique case (phase_r)
      PH_KIND: begin
        if (opt_byte == KIND_EOL) begin
          stop_nxt  = CAUSE_EOL;
          phase_nxt = PH_STOP;
        end else if (opt_byte != KIND_NOP) begin
          kind_nxt  = opt_byte;
          phase_nxt = PH_LEN;
        end
      end
      PH_LEN: begin
        // known kinds take fixed lengths, their length byte is ignored
        if (kind_r == KIND_SACKOK) begin
          sack_flag_nxt = 1'b1;
          phase_nxt     = PH_KIND;
        end else if (kind_r == KIND_MSS) begin
          field_nxt = 16'd0;
          left_nxt  = 8'd2;
          phase_nxt = PH_BODY;
        end else if (kind_r == KIND_WSCALE) begin
          field_nxt = 16'd0;
          left_nxt  = 8'd1;
          phase_nxt = PH_BODY;
        end else if (opt_byte == 8'd0) begin
          stop_nxt  = CAUSE_ZERO_LEN;
          phase_nxt = PH_STOP;
        end else if (opt_byte <= 8'd2) begin
          phase_nxt = PH_KIND;
        end else begin
          left_nxt  = opt_byte - 8'd2;
          phase_nxt = PH_BODY;
        end
      end
      PH_BODY: begin
        field_nxt = field_sh;
        left_nxt  = left_dec;
        if (left_dec == 8'd0) begin
          if (kind_r == KIND_MSS) begin
            mss_flag_nxt = 1'b1;
            mss_val_nxt  = field_sh;
          end else if (kind_r == KIND_WSCALE) begin
            scale_flag_nxt = 1'b1;
            scale_val_nxt  = field_sh[7:0];
            lshift_nxt     = LOCAL_SHIFT_ON;
          end
          phase_nxt = PH_KIND;
        end
      end
      PH_STOP: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (phase_nxt == PH_STOP) cause = stop_nxt;
    else if (phase_nxt == PH_LEN || phase_nxt == PH_BODY) cause = CAUSE_TRUNCATED;
    else cause = CAUSE_RAN_OUT;
  end

  assign res.mss_seen   = mss_flag_nxt;
  assign res.peer_mss   = mss_val_nxt;
  assign res.scale_seen = scale_flag_nxt;
  assign res.peer_shift = scale_val_nxt;
  assign res.own_shift  = lshift_nxt;
  assign res.sack_seen  = sack_flag_nxt;
  assign res.end_cause  = cause;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_KIND;
      kind_r       <= 8'd0;
      left_r       <= 8'd0;
      field_r      <= 16'd0;
      stop_r       <= CAUSE_RAN_OUT;
      mss_flag_r   <= 1'b0;
      mss_val_r    <= 16'd0;
      scale_flag_r <= 1'b0;
      scale_val_r  <= 8'd0;
      lshift_r     <= 3'd0;
      sack_flag_r  <= 1'b0;
    end else if (adv) begin
      // walk state starts over at each segment boundary
      if (last) begin
        phase_r <= PH_KIND;
        kind_r  <= 8'd0;
        left_r  <= 8'd0;
        field_r <= 16'd0;
        stop_r  <= CAUSE_RAN_OUT;
      end else begin
        phase_r <= phase_nxt;
        kind_r  <= kind_nxt;
        left_r  <= left_nxt;
        field_r <= field_nxt;
        stop_r  <= stop_nxt;
      end
      mss_flag_r   <= mss_flag_nxt;
      mss_val_r    <= mss_val_nxt;
      scale_flag_r <= scale_flag_nxt;
      scale_val_r  <= scale_val_nxt;
      lshift_r     <= lshift_nxt;
      sack_flag_r  <= sack_flag_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tcpop_obuf.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tcpop_obuf (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              load,
  input  tcpop_pkg::res_t  res,
  output logic             free,
  output logic             out_tvalid,
  input  wire              out_tready,
  output tcpop_pkg::res_t  out_res
);
  import tcpop_pkg::*;

  logic valid_r;
  res_t res_r;

  assign free       = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_res    = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tcp_option_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none

// out_tvalid rises once the last byte leaves the stage register and its result is loaded
// throughput: one option byte per cycle unless a last byte waits on the result buffer,
//   the walk state updates in one step between the input and the result register
// one result per segment, issued for the byte with in_tlast
// reset: synchronous active low, clears the walk state, sticky flags and values

module tcp_option_parser (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] option_byte
  input  wire         in_tlast,   // last_byte
  output logic        out_tvalid,
  input  wire         out_tready,
  // [0] mss_seen, [16:1] peer_mss, [17] scale_seen, [25:18] peer_shift,
  // [28:26] own_shift, [29] sack_seen, [31:30] end_cause
  output logic [31:0] out_tdata
);
  import tcpop_pkg::*;

  logic       stg_v_r;
  logic [7:0] stg_byte_r;
  logic       stg_last_r;
  logic       stg_adv;
  logic       obuf_free;
  res_t       walk_res;
  res_t       out_res;

  // a non-last byte never waits on the result side
  assign stg_adv   = stg_v_r && (!stg_last_r || obuf_free);
  assign in_tready = !stg_v_r || stg_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      stg_v_r <= 1'b1;
    end else if (stg_adv) begin
      stg_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      stg_byte_r <= in_tdata;
      stg_last_r <= in_tlast;
    end
  end

  tcpop_walk u_walk (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (stg_adv),
    .opt_byte (stg_byte_r),
    .last     (stg_last_r),
    .res      (walk_res)
  );

  tcpop_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (stg_adv && stg_last_r),
    .res        (walk_res),
    .free       (obuf_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = {out_res.end_cause, out_res.sack_seen, out_res.own_shift,
                      out_res.peer_shift, out_res.scale_seen, out_res.peer_mss,
                      out_res.mss_seen};

  a_empty_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !stg_v_r |-> in_tready)
    else $error("input stalled with empty stage");

  a_mid_byte_flows: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_v_r && !stg_last_r) |-> in_tready)
    else $error("non-last byte held back");

  a_own_shift_needs_scale: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_res.own_shift == 3'd0 || out_res.scale_seen))
    else $error("own shift set without peer scale");

  a_result_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !$past(out_tvalid)) |-> $past(stg_adv && stg_last_r))
    else $error("result without a last byte");

endmodule

`default_nettype wire
